>>> src/twcw_pkg.sv
// Shared types and constants for the text window cell writer.
package twcw_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [6:0] MAX_FILL     = 7'd64;

    localparam int ROW_W = 5;
    localparam int COL_W = 7;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_WINDOW_TOP    = 3'd0;
    localparam logic [IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TEXT_COLOR    = 3'd4;

    typedef struct packed {
        logic accept_char;
        logic accept_nl;
        logic fill_step;
    } twcw_cmd_t;

    typedef struct packed {
        logic is_newline;
        logic nl_empty;
        logic fill_last;
        logic out_free;
    } twcw_sts_t;

endpackage

>>> src/text_window_cell_writer_core.sv
// Top level of the text window cell writer: sequencer, datapath and checks.
// An ordinary character gives its cell word in the cycle after it is taken, and one
// character can be taken every cycle while the output word register drains.
// A newline loads up to 64 space cells, one per cycle while the output register drains,
// once the fill state is entered, each through the output word register; input stalls until the last loads.
// Reset is asynchronous: window registers return to the full screen, color to 7,
// the cursor to row 0 column 0, and the output register empties.
module text_window_cell_writer_core
#(
    parameter int SCREEN_WIDTH = 80
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] cell_address,
    output logic [15:0] cell_entry,
    output logic        run_last
);

    twcw_pkg::twcw_cmd_t cmd;
    twcw_pkg::twcw_sts_t sts;

    assign cfg_ready = 1'b1;

    twcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    twcw_datapath
    #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .char_code    (char_code),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .cell_address (cell_address),
        .cell_entry   (cell_entry),
        .run_last     (run_last)
    );

`ifndef SYNTHESIS
    // A fill step never coincides with taking a new input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !cmd.fill_step)
        else $error("fill step while input word taken");

    // An ordinary character shows up as a final cell on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept_char |=> (out_valid && run_last))
        else $error("character word not presented as last cell");

    // A newline with cells to write blocks input while the fill runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept_nl && !sts.nl_empty) |=> in_stall)
        else $error("input open at start of newline fill");

    // A cell that is not the last of its run means a fill is still in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_last) |-> in_stall)
        else $error("input open in the middle of a run");
`endif

endmodule

>>> src/twcw_ctrl.sv
// Sequencer that decides when a word is taken and steps the newline fill.
module twcw_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  twcw_pkg::twcw_sts_t sts,
    output twcw_pkg::twcw_cmd_t cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_FILL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = !((state_reg == ST_IDLE) && sts.out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cmd.accept_char = accept && !sts.is_newline;
        cmd.accept_nl   = accept && sts.is_newline;
        cmd.fill_step   = (state_reg == ST_FILL) && sts.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept_nl && !sts.nl_empty)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (cmd.fill_step && sts.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/twcw_datapath.sv
// Window registers, cursor, fill counter and output word register.
module twcw_datapath
#(
    parameter int SCREEN_WIDTH = 80
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [twcw_pkg::IDX_W-1:0]        cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic [7:0]                        char_code,
    input  twcw_pkg::twcw_cmd_t               cmd,
    output twcw_pkg::twcw_sts_t               sts,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic [10:0]                       cell_address,
    output logic [15:0]                       cell_entry,
    output logic                              run_last
);

    logic [twcw_pkg::ROW_W-1:0] top_reg, top_next;
    logic [twcw_pkg::ROW_W-1:0] bottom_reg, bottom_next;
    logic [twcw_pkg::COL_W-1:0] left_reg, left_next;
    logic [twcw_pkg::COL_W-1:0] right_reg, right_next;
    logic [7:0]                 color_reg, color_next;
    logic [twcw_pkg::ROW_W-1:0] row_reg, row_next;
    logic [twcw_pkg::COL_W-1:0] col_reg, col_next;
    logic [6:0]                 remain_reg, remain_next;
    logic                       out_valid_reg, out_valid_next;
    logic [10:0]                addr_reg;
    logic [15:0]                entry_reg;
    logic                       last_reg;

    logic                       home;
    logic [twcw_pkg::ROW_W:0]   row_inc;
    logic [twcw_pkg::ROW_W-1:0] wrap_row;
    logic [twcw_pkg::COL_W:0]   col_inc;
    logic [twcw_pkg::COL_W:0]   fill_count;
    logic [15:0]                addr_full;
    logic                       load;
    logic [7:0]                 load_char;

    // Row after the current one, falling back to the top row past the bottom.
    assign row_inc  = {1'b0, row_reg} + 6'd1;
    assign wrap_row = (row_inc > {1'b0, bottom_reg}) ? top_reg : row_inc[twcw_pkg::ROW_W-1:0];
    assign col_inc  = {1'b0, col_reg} + 8'd1;

    assign fill_count = {1'b0, right_reg} - {1'b0, col_reg} + 8'd1;
    assign addr_full  = 16'(row_reg) * 16'(SCREEN_WIDTH) + 16'(col_reg);

    assign sts.is_newline = (char_code == twcw_pkg::NEWLINE_CODE);
    assign sts.nl_empty   = (col_reg > right_reg);
    assign sts.fill_last  = (remain_reg == 7'd1);
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        top_next    = top_reg;
        bottom_next = bottom_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        color_next  = color_reg;
        home        = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                twcw_pkg::REG_WINDOW_TOP:
                begin
                    top_next = cfg_data[twcw_pkg::ROW_W-1:0];
                    home     = 1'b1;
                end
                twcw_pkg::REG_WINDOW_BOTTOM:
                begin
                    bottom_next = cfg_data[twcw_pkg::ROW_W-1:0];
                    home        = 1'b1;
                end
                twcw_pkg::REG_WINDOW_LEFT:
                begin
                    left_next = cfg_data[twcw_pkg::COL_W-1:0];
                    home      = 1'b1;
                end
                twcw_pkg::REG_WINDOW_RIGHT:
                begin
                    right_next = cfg_data[twcw_pkg::COL_W-1:0];
                    home       = 1'b1;
                end
                twcw_pkg::REG_TEXT_COLOR:
                begin
                    color_next = cfg_data[7:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        remain_next = remain_reg;
        priority if (home)
        begin
            row_next = top_next;
            col_next = left_next;
        end
        else if (cmd.accept_char)
        begin
            if (col_inc > {1'b0, right_reg})
            begin
                row_next = wrap_row;
                col_next = left_reg;
            end
            else
            begin
                col_next = col_inc[twcw_pkg::COL_W-1:0];
            end
        end
        else if (cmd.accept_nl)
        begin
            if (sts.nl_empty)
            begin
                row_next = wrap_row;
                col_next = left_reg;
            end
            else if (fill_count > {1'b0, twcw_pkg::MAX_FILL})
            begin
                remain_next = twcw_pkg::MAX_FILL;
            end
            else
            begin
                remain_next = fill_count[6:0];
            end
        end
        else if (cmd.fill_step)
        begin
            remain_next = remain_reg - 7'd1;
            if (sts.fill_last)
            begin
                row_next = wrap_row;
                col_next = left_reg;
            end
            else
            begin
                col_next = col_inc[twcw_pkg::COL_W-1:0];
            end
        end
        else
        begin
            remain_next = remain_reg;
        end
    end

    assign load      = cmd.accept_char || cmd.fill_step;
    assign load_char = cmd.fill_step ? twcw_pkg::SPACE_CODE : char_code;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= 5'd0;
            bottom_reg    <= 5'd24;
            left_reg      <= 7'd0;
            right_reg     <= 7'd79;
            color_reg     <= 8'd7;
            row_reg       <= '0;
            col_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg       <= top_next;
            bottom_reg    <= bottom_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            color_reg     <= color_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg  <= addr_full[10:0];
            entry_reg <= {color_reg, load_char};
            last_reg  <= cmd.accept_char || sts.fill_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_address = addr_reg;
    assign cell_entry   = entry_reg;
    assign run_last     = last_reg;

endmodule

>>> bench/tb_text_window_cell_writer_core.sv
// Self-checking testbench for the text window cell writer core.
`timescale 1ns / 1ps

module tb_text_window_cell_writer_core;

    localparam int SCREEN_W      = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 20;
    localparam int HOLD_PHASE    = 2;
    localparam int LIMIT_NS      = 40_000_000;

    // Indexes above the last register; the block must ignore them.
    localparam logic [twcw_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [twcw_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [10:0] addr;
        logic [15:0] entry;
        logic        last;
    } cell_t;

    typedef enum logic [1:0] {ROW_CHAR, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [twcw_pkg::IDX_W-1:0] idx;
        logic [31:0]                data;
        logic [7:0]                 ch;
        logic                       typed;
        cell_t                      known;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  char_code;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] cell_address;
    logic [15:0] cell_entry;
    logic        run_last;

    text_window_cell_writer_core #(
        .SCREEN_WIDTH (SCREEN_W)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_address (cell_address),
        .cell_entry   (cell_entry),
        .run_last     (run_last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Shadow copy of the window registers and the cursor.
    logic [twcw_pkg::ROW_W-1:0] win_top;
    logic [twcw_pkg::ROW_W-1:0] win_bottom;
    logic [twcw_pkg::COL_W-1:0] win_left;
    logic [twcw_pkg::COL_W-1:0] win_right;
    logic [7:0]                 attr;
    logic [twcw_pkg::ROW_W-1:0] cur_row;
    logic [twcw_pkg::COL_W-1:0] cur_col;

    cell_t     cells_due[$];
    cell_t     fresh[$];
    plan_row_t plan[$];

    int  mismatches    = 0;
    int  cells_seen    = 0;
    int  chars_sent    = 0;
    int  newlines_sent = 0;
    int  regs_written  = 0;
    int  holds_done    = 0;
    bit  hold_request  = 1'b0;
    bit  calm          = 1'b0;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic cell_t make_cell(logic [7:0] ch, logic last);
        cell_t c;
        int    a;
        a       = int'(cur_row) * SCREEN_W + int'(cur_col);
        c.addr  = a[10:0];
        c.entry = {attr, ch};
        c.last  = last;
        return c;
    endfunction

    function automatic void home_cursor();
        cur_row = win_top;
        cur_col = win_left;
    endfunction

    // Row compare is done at full width, so a row past the bottom wraps to the top.
    function automatic void to_next_row();
        int r;
        r = int'(cur_row) + 1;
        if (r > int'(win_bottom))
            r = int'(win_top);
        cur_row = r[twcw_pkg::ROW_W-1:0];
        cur_col = win_left;
    endfunction

    function automatic void apply_reg(logic [twcw_pkg::IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            twcw_pkg::REG_WINDOW_TOP:
            begin
                win_top = data[twcw_pkg::ROW_W-1:0];
                home_cursor();
            end
            twcw_pkg::REG_WINDOW_BOTTOM:
            begin
                win_bottom = data[twcw_pkg::ROW_W-1:0];
                home_cursor();
            end
            twcw_pkg::REG_WINDOW_LEFT:
            begin
                win_left = data[twcw_pkg::COL_W-1:0];
                home_cursor();
            end
            twcw_pkg::REG_WINDOW_RIGHT:
            begin
                win_right = data[twcw_pkg::COL_W-1:0];
                home_cursor();
            end
            twcw_pkg::REG_TEXT_COLOR: attr = data[7:0];
            default: ;
        endcase
    endfunction

    // Works out the cells one character causes and moves the shadow cursor.
    function automatic void predict_char(logic [7:0] ch);
        int fill;
        fresh.delete();
        if (ch == twcw_pkg::NEWLINE_CODE)
        begin
            fill = 0;
            if (cur_col <= win_right)
                fill = int'(win_right) - int'(cur_col) + 1;
            if (fill > int'(twcw_pkg::MAX_FILL))
                fill = int'(twcw_pkg::MAX_FILL);
            for (int i = 0; i < fill; i++)
            begin
                fresh.push_back(make_cell(twcw_pkg::SPACE_CODE, i == fill - 1));
                cur_col = cur_col + 7'd1;
            end
            to_next_row();
        end
        else
        begin
            fresh.push_back(make_cell(ch, 1'b1));
            if (int'(cur_col) + 1 > int'(win_right))
                to_next_row();
            else
                cur_col = cur_col + 7'd1;
        end
    endfunction

    function automatic plan_row_t row_ch(logic [7:0] ch);
        plan_row_t p;
        p = '{ROW_CHAR, twcw_pkg::REG_WINDOW_TOP, 32'd0, ch, 1'b0, '0};
        return p;
    endfunction

    function automatic plan_row_t row_known(logic [7:0] ch, logic [10:0] addr,
                                            logic [15:0] entry);
        plan_row_t p;
        p = '{ROW_CHAR, twcw_pkg::REG_WINDOW_TOP, 32'd0, ch, 1'b1, '{addr, entry, 1'b1}};
        return p;
    endfunction

    function automatic plan_row_t row_reg(logic [twcw_pkg::IDX_W-1:0] idx, logic [31:0] data);
        plan_row_t p;
        p = '{ROW_REG, idx, data, 8'd0, 1'b0, '0};
        return p;
    endfunction

    // Random upper bits in the write data; only the low bits may matter.
    function automatic logic [31:0] with_noise(logic [31:0] v, int w);
        logic [31:0] mask;
        mask = (32'd1 << w) - 32'd1;
        return ($urandom & ~mask) | (v & mask);
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic typed, input cell_t known);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= ch;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_char(ch);
        if (typed)
            cells_due.push_back(known);
        else
            foreach (fresh[i])
                cells_due.push_back(fresh[i]);
        chars_sent++;
        if (ch == twcw_pkg::NEWLINE_CODE)
            newlines_sent++;
    endtask

    task automatic write_reg(input logic [twcw_pkg::IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        regs_written++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A newline right of the window gives no cell, so also wait SETTLE_CYCLES after the queue empties.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver side: open and stalled stretches, plus one long hold-off on request.
    initial
    begin : receiver
        int open_len;
        int shut_len;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            open_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 6);
            shut_len = pick_gap();
            if (hold_request)
            begin
                shut_len     = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            if (open_len == 0 && shut_len == 0)
                open_len = 1;
            if (open_len > 0)
            begin
                out_stall <= 1'b0;
                repeat (open_len) @(posedge clk);
            end
            if (shut_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (shut_len) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_cells
        cell_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            cells_seen++;
            if (cells_due.size() == 0)
            begin
                $error("unexpected cell word: address %0d entry %h last %0d",
                       cell_address, cell_entry, run_last);
                mismatches++;
            end
            else
            begin
                want = cells_due.pop_front();
                if (cell_address !== want.addr)
                begin
                    $error("cell_address: expected %0d, got %0d", want.addr, cell_address);
                    mismatches++;
                end
                if (cell_entry !== want.entry)
                begin
                    $error("cell_entry: expected %h, got %h", want.entry, cell_entry);
                    mismatches++;
                end
                if (run_last !== want.last)
                begin
                    $error("run_last: expected %0d, got %0d", want.last, run_last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("tb_text_window_cell_writer_core failed");
        $finish;
    end

    initial
    begin : stimulus
        int                         mode;
        int                         r;
        logic [twcw_pkg::ROW_W-1:0] t;
        logic [twcw_pkg::ROW_W-1:0] b;
        logic [twcw_pkg::COL_W-1:0] lc;
        logic [twcw_pkg::COL_W-1:0] rc;
        logic [7:0]                 ch;

        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        char_code  = '0;
        win_top    = 5'd0;
        win_bottom = 5'd24;
        win_left   = 7'd0;
        win_right  = 7'd79;
        attr       = 8'd7;
        home_cursor();

        // Directed part: reset window and color, byte extremes, long fill, color
        // extremes, bottom-row wrap, inverted windows, one-column window, fill
        // with the cursor right of the window, counter-maximum edges, addresses
        // off the screen, spare indexes, and fills of exactly and over 64 cells.
        plan.push_back(row_known(8'h41, 11'd0, 16'h0741));
        plan.push_back(row_known(8'h00, 11'd1, 16'h0700));
        plan.push_back(row_known(8'hFF, 11'd2, 16'h07FF));
        plan.push_back(row_ch(twcw_pkg::NEWLINE_CODE));
        plan.push_back(row_known(8'h78, 11'd80, 16'h0778));
        plan.push_back(row_reg(twcw_pkg::REG_TEXT_COLOR, 32'hFFFF_FFFF));
        plan.push_back(row_known(8'h55, 11'd81, 16'hFF55));
        plan.push_back(row_reg(twcw_pkg::REG_TEXT_COLOR, 32'h0000_0000));
        plan.push_back(row_known(8'hAA, 11'd82, 16'h00AA));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_TOP, 32'd24));
        plan.push_back(row_known(8'h31, 11'd1920, 16'h0031));
        plan.push_back(row_ch(twcw_pkg::NEWLINE_CODE));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_BOTTOM, 32'd0));
        plan.push_back(row_ch(8'h01));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_TOP, 32'd0));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_LEFT, 32'd79));
        plan.push_back(row_known(8'h7A, 11'd79, 16'h007A));
        plan.push_back(row_known(twcw_pkg::NEWLINE_CODE, 11'd79, 16'h0020));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_LEFT, 32'd5));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_RIGHT, 32'd2));
        plan.push_back(row_ch(twcw_pkg::NEWLINE_CODE));
        plan.push_back(row_ch(8'h80));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_LEFT, 32'hFFFF_FFF8));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_RIGHT, 32'h0000_007F));
        plan.push_back(row_ch(twcw_pkg::NEWLINE_CODE));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_BOTTOM, 32'hFFFF_FFFF));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_TOP, 32'd31));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_LEFT, 32'd126));
        plan.push_back(row_ch(8'h5A));
        plan.push_back(row_ch(8'hA5));
        plan.push_back(row_ch(8'h3C));
        plan.push_back(row_reg(REG_SPARE_LO, 32'hDEAD_BEEF));
        plan.push_back(row_reg(REG_SPARE_HI, 32'h0000_0000));
        plan.push_back(row_ch(8'h0F));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_TOP, 32'd2));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_BOTTOM, 32'd24));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_LEFT, 32'd0));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_RIGHT, 32'd63));
        plan.push_back(row_ch(twcw_pkg::NEWLINE_CODE));
        plan.push_back(row_reg(twcw_pkg::REG_WINDOW_RIGHT, 32'd64));
        plan.push_back(row_ch(twcw_pkg::NEWLINE_CODE));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                wait_drained();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                push_char(plan[i].ch, plan[i].typed, plan[i].known);
        end

        // Random part: each phase picks a window or keeps the last one, then streams characters.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            mode = (phase == 0) ? 0 : $urandom_range(0, 4);
            t  = 5'd0;
            b  = 5'd24;
            lc = 7'd0;
            rc = 7'd79;
            case (mode)
                1:
                begin
                    t  = 5'($urandom_range(0, 24));
                    b  = t + 5'($urandom_range(0, 3));
                    lc = 7'($urandom_range(0, 79));
                    rc = lc + 7'($urandom_range(0, 15));
                end
                2:
                begin
                    t  = 5'($urandom);
                    b  = 5'($urandom);
                    lc = 7'($urandom);
                    rc = 7'($urandom);
                end
                3:
                begin
                    t  = $urandom_range(0, 1) ? 5'd31 : 5'd0;
                    b  = $urandom_range(0, 1) ? 5'd31 : 5'd0;
                    lc = $urandom_range(0, 1) ? 7'd127 : 7'd0;
                    rc = $urandom_range(0, 1) ? 7'd127 : 7'd0;
                end
                default: ;
            endcase
            // Mode 4 keeps the window and cursor from the previous phase.
            if (mode != 4)
            begin
                write_reg(twcw_pkg::REG_WINDOW_TOP, with_noise(32'(t), twcw_pkg::ROW_W));
                write_reg(twcw_pkg::REG_WINDOW_BOTTOM, with_noise(32'(b), twcw_pkg::ROW_W));
                write_reg(twcw_pkg::REG_WINDOW_LEFT, with_noise(32'(lc), twcw_pkg::COL_W));
                write_reg(twcw_pkg::REG_WINDOW_RIGHT, with_noise(32'(rc), twcw_pkg::COL_W));
                write_reg(twcw_pkg::REG_TEXT_COLOR, with_noise(32'($urandom), 8));
                if ($urandom_range(0, 3) == 0)
                    write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
            end
            if (phase == HOLD_PHASE)
            begin
                hold_request = 1'b1;
                calm         = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r  = $urandom_range(0, 99);
                ch = (r < 22) ? twcw_pkg::NEWLINE_CODE : 8'($urandom_range(0, 255));
                push_char(ch, 1'b0, '0);
            end
            calm = 1'b0;
        end

        wait_drained();

        $display("run covered %0d characters (%0d newlines) and %0d register writes",
                 chars_sent, newlines_sent, regs_written);
        $display("%0d cell words checked, %0d long receiver hold-offs",
                 cells_seen, holds_done);
        if (mismatches == 0)
            $display("tb_text_window_cell_writer_core passed");
        else
            $display("tb_text_window_cell_writer_core failed");
        $finish;
    end

endmodule

>>> text_window_cell_writer_core.f
src/twcw_pkg.sv
src/twcw_ctrl.sv
src/twcw_datapath.sv
src/text_window_cell_writer_core.sv
bench/tb_text_window_cell_writer_core.sv
